// ===== hw/rtl/i2crtc_pkg.sv =====
// shared types, codes and helpers for the i2c rtc time reader
package i2crtc_pkg;

	localparam int AddrW  = 7;
	localparam int RegW   = 8;
	localparam int TickW  = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;
	localparam int InDataW = 8;
	localparam int OutDataW = 32;

	localparam logic [AddrW-1:0] DevAddrReset  = 7'h68;
	localparam logic [RegW-1:0]  FirstRegReset = 8'h00;
	localparam logic [TickW-1:0] TicksReset    = 16'd40;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEVICE_ADDRESS  = 2'd0,
		CFG_FIRST_REGISTER  = 2'd1,
		CFG_TICKS_PER_DELAY = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'd0,
		ST_ST0     = 5'd1,
		ST_ST1     = 5'd2,
		ST_ST2     = 5'd3,
		ST_WB_SET  = 5'd4,
		ST_WB_HIGH = 5'd5,
		ST_WB_LOW  = 5'd6,
		ST_WA_REL  = 5'd7,
		ST_WA_HIGH = 5'd8,
		ST_WA_LOW  = 5'd9,
		ST_RB_HIGH = 5'd10,
		ST_RB_LOW  = 5'd11,
		ST_RA_SET  = 5'd12,
		ST_RA_HIGH = 5'd13,
		ST_RA_LOW  = 5'd14,
		ST_SP0     = 5'd15,
		ST_SP1     = 5'd16,
		ST_SP2     = 5'd17
	} seq_state_t;

	typedef struct packed {
		logic [AddrW-1:0] device_address;
		logic [RegW-1:0]  first_register;
		logic [TickW-1:0] ticks_per_delay;
	} cfg_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] seconds;
		logic [7:0] minutes;
		logic [5:0] hours;
		logic       nack_seen;
	} res_t;

	// tens * 10 + units, tens*10 built from shifts
	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		logic [7:0] tens;
		tens = {4'd0, b[7:4]};
		return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
	endfunction

endpackage

// ===== hw/rtl/i2c_rtc_time_reader.sv =====
// i2c rtc time reader top level: config port, sequencer and output register
// latency: the result of an input transfer is on m_tdata in the cycle after it is accepted
// throughput: one input transfer per cycle while the output side keeps up, set by the single-tick sequencer step
// an output register decouples the sides; input is taken while a result waits
// if the output side takes it in the same cycle
// reset: async active low, lines released, stores cleared, config to defaults
module i2c_rtc_time_reader
	import i2crtc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // go, sda_in, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	// scl_drive_low, sda_drive_low, busy_res, done_res, seconds[7:0],
	// minutes[7:0], hours[5:0], nack_seen, zero pad
	output logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t                cfg;
	res_t                res;
	logic                accept;
	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	i2crtc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2crtc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (accept),
		.go     (s_tdata[0]),
		.sda_in (s_tdata[1]),
		.res    (res)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'd0, res.nack_seen, res.hours, res.minutes, res.seconds,
				res.done_res, res.busy_res, res.sda_drive_low, res.scl_drive_low};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hw/rtl/i2crtc_cfg.sv =====
// configuration register file
module i2crtc_cfg
	import i2crtc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address  <= DevAddrReset;
			cfg_q.first_register  <= FirstRegReset;
			cfg_q.ticks_per_delay <= TicksReset;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_DEVICE_ADDRESS:  cfg_q.device_address  <= cfg_wdata[AddrW-1:0];
				CFG_FIRST_REGISTER:  cfg_q.first_register  <= cfg_wdata[RegW-1:0];
				CFG_TICKS_PER_DELAY: cfg_q.ticks_per_delay <= cfg_wdata[TickW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/i2crtc_seq.sv =====
// bus sequencer: one tick per transfer, drives scl/sda and collects the time bytes
module i2crtc_seq
	import i2crtc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic tick,
	input  logic go,
	input  logic sda_in,
	output res_t res
);

	seq_state_t       state_q, state_d;
	logic [3:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic [1:0]       byte_q, byte_d;
	logic [TickW-1:0] pre_q, pre_d;
	logic             scl_q, scl_d;
	logic             sda_q, sda_d;
	logic [7:0]       sec_q, sec_d;
	logic [7:0]       min_q, min_d;
	logic [5:0]       hrs_q, hrs_d;
	logic             nack_q, nack_d;

	logic [TickW-1:0] limit;
	logic [TickW:0]   pre_inc;
	logic [3:0]       bit_inc;
	logic [7:0]       shl;
	logic [7:0]       hrs_bcd;
	logic [7:0]       addr_byte;
	logic             scl_out, sda_out, busy, done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (tick) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q   <= '0;
			shift_q <= '0;
			byte_q  <= '0;
			pre_q   <= '0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			sec_q   <= '0;
			min_q   <= '0;
			hrs_q   <= '0;
			nack_q  <= 1'b0;
		end else if (tick) begin
			bit_q   <= bit_d;
			shift_q <= shift_d;
			byte_q  <= byte_d;
			pre_q   <= pre_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			sec_q   <= sec_d;
			min_q   <= min_d;
			hrs_q   <= hrs_d;
			nack_q  <= nack_d;
		end
	end

	assign limit = (cfg.ticks_per_delay == '0) ? TickW'(1) : cfg.ticks_per_delay;

	always_comb begin
		state_d = state_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		byte_d  = byte_q;
		pre_d   = pre_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		sec_d   = sec_q;
		min_d   = min_q;
		hrs_d   = hrs_q;
		nack_d  = nack_q;
		done    = 1'b0;

		// go tick is also the first tick of the first slot
		if (state_q == ST_IDLE && go) begin
			state_d = ST_ST0;
			nack_d  = 1'b0;
			byte_d  = '0;
			bit_d   = '0;
			shift_d = '0;
			pre_d   = '0;
			scl_d   = 1'b0;
			sda_d   = 1'b0;
		end

		scl_out = scl_d;
		sda_out = sda_d;
		busy    = (state_d != ST_IDLE);

		pre_inc   = {1'b0, pre_d} + 1'b1;
		bit_inc   = bit_d + 4'd1;
		shl       = {shift_d[6:0], 1'b0};
		hrs_bcd   = from_bcd({2'b00, shift_d[5:0]});
		addr_byte = {cfg.device_address, (byte_d == 2'd2)};

		if (busy) begin
			if (pre_inc >= {1'b0, limit}) begin
				pre_d = '0;
				case (state_d)
					ST_ST0: begin
						state_d = ST_ST1; scl_d = 1'b0; sda_d = 1'b1;
					end
					ST_ST1: begin
						state_d = ST_ST2; scl_d = 1'b1; sda_d = 1'b1;
					end
					ST_ST2: begin
						shift_d = addr_byte;
						bit_d   = '0;
						state_d = ST_WB_SET; scl_d = 1'b1; sda_d = ~addr_byte[7];
					end
					ST_WB_SET: begin
						state_d = ST_WB_HIGH; scl_d = 1'b0;
					end
					ST_WB_HIGH: begin
						state_d = ST_WB_LOW; scl_d = 1'b1;
					end
					ST_WB_LOW: begin
						shift_d = shl;
						bit_d   = bit_inc;
						scl_d   = 1'b1;
						if (bit_inc >= 4'd8) begin
							state_d = ST_WA_REL; sda_d = 1'b0;
						end else begin
							state_d = ST_WB_SET; sda_d = ~shl[7];
						end
					end
					ST_WA_REL: begin
						state_d = ST_WA_HIGH; scl_d = 1'b0; sda_d = 1'b0;
					end
					ST_WA_HIGH: begin
						if (sda_in) nack_d = 1'b1;
						state_d = ST_WA_LOW; scl_d = 1'b1; sda_d = 1'b0;
					end
					ST_WA_LOW: begin
						if (byte_d == 2'd0) begin
							byte_d  = 2'd1;
							shift_d = cfg.first_register;
							bit_d   = '0;
							state_d = ST_WB_SET; scl_d = 1'b1;
							sda_d   = ~cfg.first_register[7];
						end else if (byte_d == 2'd1) begin
							// repeated start
							byte_d  = 2'd2;
							state_d = ST_ST0; scl_d = 1'b0; sda_d = 1'b0;
						end else begin
							byte_d  = '0;
							shift_d = '0;
							bit_d   = '0;
							state_d = ST_RB_HIGH; scl_d = 1'b0; sda_d = 1'b0;
						end
					end
					ST_RB_HIGH: begin
						shift_d = {shift_d[6:0], sda_in};
						state_d = ST_RB_LOW; scl_d = 1'b1; sda_d = 1'b0;
					end
					ST_RB_LOW: begin
						bit_d = bit_inc;
						if (bit_inc >= 4'd8) begin
							if (byte_d == 2'd0)      sec_d = from_bcd(shift_d);
							else if (byte_d == 2'd1) min_d = from_bcd(shift_d);
							else                     hrs_d = hrs_bcd[5:0];
							// ack the first two bytes, nack the last
							state_d = ST_RA_SET; scl_d = 1'b1; sda_d = (byte_d < 2'd2);
						end else begin
							state_d = ST_RB_HIGH; scl_d = 1'b0; sda_d = 1'b0;
						end
					end
					ST_RA_SET: begin
						state_d = ST_RA_HIGH; scl_d = 1'b0;
					end
					ST_RA_HIGH: begin
						state_d = ST_RA_LOW; scl_d = 1'b1;
					end
					ST_RA_LOW: begin
						if (byte_d >= 2'd2) begin
							byte_d  = '0;
							state_d = ST_SP0; scl_d = 1'b1; sda_d = 1'b1;
						end else begin
							byte_d  = byte_d + 2'd1;
							shift_d = '0;
							bit_d   = '0;
							state_d = ST_RB_HIGH; scl_d = 1'b0; sda_d = 1'b0;
						end
					end
					ST_SP0: begin
						state_d = ST_SP1; scl_d = 1'b0; sda_d = 1'b1;
					end
					ST_SP1: begin
						state_d = ST_SP2; scl_d = 1'b0; sda_d = 1'b0;
					end
					default: begin
						state_d = ST_IDLE; scl_d = 1'b0; sda_d = 1'b0;
						bit_d   = '0;
						byte_d  = '0;
						shift_d = '0;
						done    = 1'b1;
					end
				endcase
			end else begin
				pre_d = pre_inc[TickW-1:0];
			end
		end

		res.scl_drive_low = scl_out;
		res.sda_drive_low = sda_out;
		res.busy_res      = busy;
		res.done_res      = done;
		res.seconds       = sec_d;
		res.minutes       = min_d;
		res.hours         = hrs_d;
		res.nack_seen     = nack_d;
	end

endmodule

// ===== test/tb_top.sv =====
// testbench for the i2c rtc time reader: tick stream in, bus drive and time values out
`timescale 1ns / 100ps

module tb_top
	import i2crtc_pkg::*;
();

	localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

	// slot layout of one read transaction
	localparam int AckSlotAddrW  = 28;
	localparam int AckSlotPtr    = 55;
	localparam int AckSlotAddrR  = 85;
	localparam int FirstReadSlot = 87;
	localparam int ReadByteSlots = 19;
	localparam int ReadBitSlots  = 16;
	localparam int StopSlot      = 144;
	localparam int SlotsTotal    = 147;

	localparam int IdlePct    = 36;
	localparam int ItemTarget = 1900;
	localparam int HoldCycles = 200;

	typedef struct {
		logic       scl_low;
		logic       sda_low;
		logic       busy;
		logic       done;
		logic [7:0] seconds;
		logic [7:0] minutes;
		logic [5:0] hours;
		logic       nack;
	} bus_tick_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_addr  = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	i2c_rtc_time_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------- sequencer prediction ----------------
	seq_state_t       bus_step   = ST_IDLE;
	logic [3:0]       bit_idx    = '0;
	logic [7:0]       shreg      = '0;
	logic [1:0]       byte_idx   = '0;
	logic [15:0]      slot_ticks = '0;
	logic             scl_low    = 1'b0;
	logic             sda_low    = 1'b0;
	logic [7:0]       sec_val    = '0;
	logic [7:0]       min_val    = '0;
	logic [5:0]       hr_val     = '0;
	logic             nack_hold  = 1'b0;
	logic [AddrW-1:0] dev_addr   = DevAddrReset;
	logic [RegW-1:0]  reg_ptr    = FirstRegReset;
	logic [TickW-1:0] slot_len   = TicksReset;

	bus_tick_t expected_ticks[$];
	int mismatches = 0;

	function automatic logic [7:0] bcd_to_bin(logic [7:0] b);
		return b[7:4] * 8'd10 + {4'd0, b[3:0]};
	endfunction

	function automatic void enter_slot(seq_state_t st, logic scl, logic sda);
		bus_step = st;
		slot_ticks = '0;
		scl_low = scl;
		sda_low = sda;
	endfunction

	function automatic void start_byte(logic [7:0] v);
		shreg = v;
		bit_idx = '0;
		enter_slot(ST_WB_SET, 1'b1, ~v[7]);
	endfunction

	// end of the current slot, returns 1 when the transaction is over
	function automatic logic end_slot(logic sda_in);
		logic [7:0] hr_full;
		case (bus_step)
			ST_ST0: enter_slot(ST_ST1, 1'b0, 1'b1);
			ST_ST1: enter_slot(ST_ST2, 1'b1, 1'b1);
			ST_ST2: start_byte({dev_addr, byte_idx == 2'd2});
			ST_WB_SET: enter_slot(ST_WB_HIGH, 1'b0, sda_low);
			ST_WB_HIGH: enter_slot(ST_WB_LOW, 1'b1, sda_low);
			ST_WB_LOW: begin
				shreg = shreg << 1;
				bit_idx = bit_idx + 1'b1;
				if (bit_idx >= 4'd8)
					enter_slot(ST_WA_REL, 1'b1, 1'b0);
				else
					enter_slot(ST_WB_SET, 1'b1, ~shreg[7]);
			end
			ST_WA_REL: enter_slot(ST_WA_HIGH, 1'b0, 1'b0);
			ST_WA_HIGH: begin
				if (sda_in)
					nack_hold = 1'b1;
				enter_slot(ST_WA_LOW, 1'b1, 1'b0);
			end
			ST_WA_LOW: begin
				if (byte_idx == 2'd0) begin
					byte_idx = 2'd1;
					start_byte(reg_ptr);
				end else if (byte_idx == 2'd1) begin
					// repeated start before the address with read
					byte_idx = 2'd2;
					enter_slot(ST_ST0, 1'b0, 1'b0);
				end else begin
					byte_idx = 2'd0;
					shreg = '0;
					bit_idx = '0;
					enter_slot(ST_RB_HIGH, 1'b0, 1'b0);
				end
			end
			ST_RB_HIGH: begin
				shreg = {shreg[6:0], sda_in};
				enter_slot(ST_RB_LOW, 1'b1, 1'b0);
			end
			ST_RB_LOW: begin
				bit_idx = bit_idx + 1'b1;
				if (bit_idx >= 4'd8) begin
					if (byte_idx == 2'd0) begin
						sec_val = bcd_to_bin(shreg);
					end else if (byte_idx == 2'd1) begin
						min_val = bcd_to_bin(shreg);
					end else begin
						hr_full = bcd_to_bin({2'b00, shreg[5:0]});
						hr_val = hr_full[5:0];
					end
					// ack the first two bytes, nack the last
					enter_slot(ST_RA_SET, 1'b1, byte_idx < 2'd2);
				end else begin
					enter_slot(ST_RB_HIGH, 1'b0, 1'b0);
				end
			end
			ST_RA_SET: enter_slot(ST_RA_HIGH, 1'b0, sda_low);
			ST_RA_HIGH: enter_slot(ST_RA_LOW, 1'b1, sda_low);
			ST_RA_LOW: begin
				if (byte_idx >= 2'd2) begin
					byte_idx = 2'd0;
					enter_slot(ST_SP0, 1'b1, 1'b1);
				end else begin
					byte_idx = byte_idx + 1'b1;
					shreg = '0;
					bit_idx = '0;
					enter_slot(ST_RB_HIGH, 1'b0, 1'b0);
				end
			end
			ST_SP0: enter_slot(ST_SP1, 1'b0, 1'b1);
			ST_SP1: enter_slot(ST_SP2, 1'b0, 1'b0);
			default: begin
				enter_slot(ST_IDLE, 1'b0, 1'b0);
				bit_idx = '0;
				byte_idx = '0;
				shreg = '0;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic bus_tick_t predict_tick(logic go, logic sda_in);
		bus_tick_t r;
		int unsigned lim;
		lim = (slot_len == '0) ? 1 : slot_len;
		r = '{default: '0};
		if (bus_step == ST_IDLE && go) begin
			nack_hold = 1'b0;
			byte_idx = '0;
			bit_idx = '0;
			shreg = '0;
			enter_slot(ST_ST0, 1'b0, 1'b0);
		end
		r.scl_low = scl_low;
		r.sda_low = sda_low;
		if (bus_step != ST_IDLE) begin
			r.busy = 1'b1;
			if (int'(slot_ticks) + 1 >= lim)
				r.done = end_slot(sda_in);
			else
				slot_ticks = slot_ticks + 1'b1;
		end
		r.seconds = sec_val;
		r.minutes = min_val;
		r.hours = hr_val;
		r.nack = nack_hold;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------- tick stream generation ----------------
	logic [InDataW-1:0] tick_q[$];
	int         ticks_queued  = 0;
	int         gen_pos       = -1;
	int         gen_slot_len  = TicksReset;
	int         gen_nack_pct  = 0;
	logic [7:0] gen_bytes[3];

	function automatic void push_tick(logic go, logic sda);
		tick_q.push_back({{(InDataW-2){1'b0}}, sda, go});
		ticks_queued++;
	endfunction

	// one tick; while a read is running, sda answers acks and carries the time bytes
	function automatic void gen_tick(logic want_go);
		logic go;
		logic sda;
		int s;
		int r;
		sda = 1'($urandom_range(1));
		if (gen_pos < 0) begin
			go = want_go;
			if (go)
				gen_pos = 0;
		end else begin
			go = 1'($urandom_range(1));
		end
		if (gen_pos >= 0) begin
			s = gen_pos / gen_slot_len;
			if (gen_pos % gen_slot_len == gen_slot_len - 1) begin
				if (s == AckSlotAddrW || s == AckSlotPtr || s == AckSlotAddrR) begin
					sda = ($urandom_range(99) < gen_nack_pct);
				end else if (s >= FirstReadSlot && s < StopSlot) begin
					r = s - FirstReadSlot;
					if (r % ReadByteSlots < ReadBitSlots && r % 2 == 0)
						sda = gen_bytes[r / ReadByteSlots][7 - (r % ReadByteSlots) / 2];
				end
			end
			gen_pos++;
			if (gen_pos == SlotsTotal * gen_slot_len)
				gen_pos = -1;
		end
		push_tick(go, sda);
	endfunction

	function automatic void finish_read();
		while (gen_pos >= 0)
			gen_tick(1'b0);
	endfunction

	function automatic void time_read(int nack_pct, logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2);
		finish_read();
		gen_nack_pct = nack_pct;
		gen_bytes[0] = b0;
		gen_bytes[1] = b1;
		gen_bytes[2] = b2;
		gen_tick(1'b1);
		finish_read();
		repeat ($urandom_range(6))
			gen_tick($urandom_range(3) == 0);
	endfunction

	function automatic logic [7:0] bcd_byte(int max_tens);
		logic [3:0] t;
		logic [3:0] u;
		t = 4'($urandom_range(max_tens));
		u = 4'($urandom_range(9));
		return {t, u};
	endfunction

	// ---------------- driver ----------------
	int ticks_sent = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (tick_q.size() != 0 && ((ticks_sent >= 700 && ticks_sent < 1000)
					|| $urandom_range(99) >= IdlePct)) begin
				s_tvalid <= 1'b1;
				s_tdata <= tick_q.pop_front();
				ticks_sent++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- monitor and receiver ----------------
	int results_seen = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		bus_tick_t want;
		logic [OutDataW-1:0] got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_DEVICE_ADDRESS: dev_addr = cfg_wdata[AddrW-1:0];
					CFG_FIRST_REGISTER: reg_ptr = cfg_wdata[RegW-1:0];
					CFG_TICKS_PER_DELAY: slot_len = cfg_wdata[TickW-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = m_tdata;
				if (expected_ticks.size() == 0) begin
					$error("result transfer with nothing expected: %h", got);
					mismatches++;
				end else begin
					want = expected_ticks.pop_front();
					check_field("scl_drive_low", want.scl_low, got[0]);
					check_field("sda_drive_low", want.sda_low, got[1]);
					check_field("busy_res", want.busy, got[2]);
					check_field("done_res", want.done, got[3]);
					check_field("seconds", want.seconds, got[11:4]);
					check_field("minutes", want.minutes, got[19:12]);
					check_field("hours", want.hours, got[25:20]);
					check_field("nack_seen", want.nack, got[26]);
				end
				// long back-pressure so the block fills and stalls its input
				if (results_seen == 600 || results_seen == 1500)
					hold_left = HoldCycles;
			end
			if (s_tvalid && s_tready)
				expected_ticks.push_back(predict_tick(s_tdata[0], s_tdata[1]));
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= (results_seen >= 800 && results_seen < 1100)
					|| $urandom_range(99) >= IdlePct;
			end
		end
	end

	// ---------------- sequence ----------------
	task automatic drain();
		do
			@(posedge clk);
		while (tick_q.size() != 0 || s_tvalid || expected_ticks.size() != 0);
		// let the output register settle before touching the registers
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_slot_len(logic [TickW-1:0] value);
		write_reg(CFG_TICKS_PER_DELAY, value);
		gen_slot_len = (value == '0) ? 1 : value;
	endtask

	initial begin
		int pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle ticks, then a go that starts a long slot
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b1);
		repeat (10)
			push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		drain();

		// register writes in the middle of a read
		write_reg(CFG_DEVICE_ADDRESS, 16'h007F);
		write_reg(CFG_FIRST_REGISTER, 16'h00FF);
		write_reg(CfgIdxUnused, 16'($urandom));
		set_slot_len(16'hFFFF);
		repeat (8)
			push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		drain();

		// zero delay acts as one tick; flush the open read
		set_slot_len(16'h0000);
		repeat (SlotsTotal + 3)
			push_tick(1'b0, 1'($urandom_range(1)));
		gen_pos = -1;
		time_read(100, 8'hFF, 8'hFF, 8'hFF);
		time_read(0, 8'h00, 8'h00, 8'h00);
		drain();

		write_reg(CFG_DEVICE_ADDRESS, 16'h0000);
		write_reg(CFG_FIRST_REGISTER, 16'h0000);
		set_slot_len(16'd1);
		time_read(0, 8'h59, 8'h59, 8'h23);
		drain();

		while (ticks_queued < ItemTarget) begin
			write_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
			write_reg(CFG_FIRST_REGISTER, 16'($urandom));
			pick = $urandom_range(3);
			set_slot_len((pick == 0) ? 16'd1 : 16'(pick));
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(99) < 80)
					time_read(($urandom_range(3) == 0) ? 10 : 0, bcd_byte(5),
						bcd_byte(5), bcd_byte(2));
				else
					time_read(50, 8'($urandom), 8'($urandom), 8'($urandom));
			end
			finish_read();
			drain();
		end

		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
